FILE: rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths and controller/datapath interface types for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

	localparam int WIDTH     = 32;
	localparam int EXP_WIDTH = 32;
	localparam int CNT_W     = $clog2(WIDTH);

	typedef enum logic [1:0] {
		MUL_REDUCE = 2'd0,
		MUL_MULT   = 2'd1,
		MUL_SQUARE = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     zero_res;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     mul_step;
		logic     exp_shift;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic mod_small;
		logic mul_last;
		logic exp_zero;
		logic exp_lsb;
		logic exp_next_zero;
	} sts_t;

endpackage

FILE: rtl/mexp_dp.sv
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: operand registers, exponent shifter, one bit-serial modular
// multiplier (one multiplier bit per cycle) and the result register.
// ----------------------------------------------------------------------------
module mexp_dp (
	input  logic                           clk,
	input  logic [mexp_pkg::WIDTH-1:0]     base_value,
	input  logic [mexp_pkg::EXP_WIDTH-1:0] power,
	input  logic [mexp_pkg::WIDTH-1:0]     modulus_value,
	input  mexp_pkg::cmd_t                 cmd,
	output mexp_pkg::sts_t                 sts,
	output logic [mexp_pkg::WIDTH-1:0]     residue
);
	import mexp_pkg::*;

	localparam int SW = WIDTH + 2;

	logic [WIDTH-1:0]     m_q;
	logic [WIDTH-1:0]     b_q;
	logic [WIDTH-1:0]     acc_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic [WIDTH-1:0]     mul_a_q;
	logic [WIDTH-1:0]     mul_b_q;
	logic [WIDTH-1:0]     mul_p_q;
	logic [CNT_W-1:0]     cnt_q;
	mul_sel_t             sel_q;
	logic [WIDTH-1:0]     res_q;

	logic [SW-1:0]    sum;
	logic [SW-1:0]    diff1;
	logic [SW-1:0]    diff2;
	logic [WIDTH-1:0] step_p;

	// 2p + bit*a is below 3m, so subtract m or 2m
	always_comb begin
		sum   = {1'b0, mul_p_q, 1'b0}
			+ (mul_b_q[WIDTH-1] ? {2'b00, mul_a_q} : {SW{1'b0}});
		diff1 = sum - {2'b00, m_q};
		diff2 = sum - {1'b0, m_q, 1'b0};
		priority if (!diff2[SW-1]) begin
			step_p = diff2[WIDTH-1:0];
		end else if (!diff1[SW-1]) begin
			step_p = diff1[WIDTH-1:0];
		end else begin
			step_p = sum[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q   <= modulus_value;
			b_q   <= base_value;
			e_q   <= power;
			acc_q <= WIDTH'(1);
		end
		if (cmd.zero_res) begin
			acc_q <= '0;
		end
		if (cmd.exp_shift) begin
			e_q <= e_q >> 1;
		end
		if (cmd.mul_step && cnt_q == '0) begin
			unique case (sel_q)
				MUL_MULT: begin
					acc_q <= step_p;
				end
				MUL_REDUCE, MUL_SQUARE: begin
					b_q <= step_p;
				end
				default: begin
					b_q <= step_p;
				end
			endcase
		end
		if (cmd.mul_start) begin
			sel_q   <= cmd.mul_sel;
			mul_p_q <= '0;
			cnt_q   <= CNT_W'(WIDTH - 1);
			mul_b_q <= b_q;
			unique case (cmd.mul_sel)
				MUL_REDUCE: begin
					mul_a_q <= WIDTH'(1);
				end
				MUL_MULT: begin
					mul_a_q <= acc_q;
				end
				MUL_SQUARE: begin
					mul_a_q <= b_q;
				end
				default: begin
					mul_a_q <= b_q;
				end
			endcase
		end else if (cmd.mul_step) begin
			mul_p_q <= step_p;
			mul_b_q <= mul_b_q << 1;
			cnt_q   <= cnt_q - CNT_W'(1);
		end
		if (cmd.out_load) begin
			res_q <= acc_q;
		end
	end

	always_comb begin
		sts.mod_small     = (m_q >> 1) == '0;
		sts.mul_last      = cnt_q == '0;
		sts.exp_zero      = e_q == '0;
		sts.exp_lsb       = e_q[0];
		sts.exp_next_zero = (e_q >> 1) == '0;
	end

	assign residue = res_q;

endmodule

FILE: rtl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// mexp_ctrl
// Controller: sequences base reduction, the square-and-multiply loop over
// the exponent bits and the hand-off into the output register.
// ----------------------------------------------------------------------------
module mexp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  mexp_pkg::sts_t sts,
	output mexp_pkg::cmd_t cmd
);
	import mexp_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_START  = 7'b0000010,
		ST_REDUCE = 7'b0000100,
		ST_TEST   = 7'b0001000,
		ST_MULT   = 7'b0010000,
		ST_SQUARE = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != ST_IDLE;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_sel   = MUL_REDUCE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.mod_small) begin
					cmd.zero_res = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_REDUCE;
					state_d       = ST_REDUCE;
				end
			end
			ST_REDUCE: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				priority if (sts.exp_zero) begin
					state_d = ST_EMIT;
				end else if (sts.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MUL_MULT;
					state_d       = ST_MULT;
				end else begin
					cmd.exp_shift = 1'b1;
					if (sts.exp_next_zero) begin
						state_d = ST_EMIT;
					end else begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = MUL_SQUARE;
						state_d       = ST_SQUARE;
					end
				end
			end
			ST_MULT: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					cmd.exp_shift = 1'b1;
					if (sts.exp_next_zero) begin
						state_d = ST_EMIT;
					end else begin
						cmd.mul_start = 1'b1;
						cmd.mul_sel   = MUL_SQUARE;
						state_d       = ST_SQUARE;
					end
				end
			end
			ST_SQUARE: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_last) begin
					state_d = ST_TEST;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Computes base_value ** power mod modulus_value by right-to-left binary
// square-and-multiply with a bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with base_value, power, modulus_value;
//   a beat is taken when in_valid is high and in_stall is low
//   output channel: out_valid / out_stall with residue, held while stalled
//   one item is worked on at a time; in_stall is high from acceptance until
//   the result is moved into the output register
//   base reduction is one of the modular multiplies, by the constant one
//   the next beat can be taken in the cycle after the result is loaded, even
//   while that result waits; the block waits only if a new result finds it full
//   reset clears the controller and the output valid; no result is pending
// ----------------------------------------------------------------------------
module modular_exponentiation (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [mexp_pkg::WIDTH-1:0]     base_value,
	input  logic [mexp_pkg::EXP_WIDTH-1:0] power,
	input  logic [mexp_pkg::WIDTH-1:0]     modulus_value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mexp_pkg::WIDTH-1:0]     residue
);
	import mexp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	mexp_dp u_dp (
		.clk           (clk),
		.base_value    (base_value),
		.power         (power),
		.modulus_value (modulus_value),
		.cmd           (cmd),
		.sts           (sts),
		.residue       (residue)
	);

endmodule

FILE: tb/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the square-and-multiply exponentiation block.
// A directed set covers modulus one, exponent zero, full-width operands and
// base reduction. Random beats follow under phases of sender idling and
// receiver stalling. Every accepted beat is predicted in a scoreboard and
// every result beat is compared in order against it.
// ----------------------------------------------------------------------------

typedef logic [mexp_pkg::WIDTH-1:0]     word_t;
typedef logic [mexp_pkg::EXP_WIDTH-1:0] exp_t;

class residue_board;
	word_t pending[$];
	int    errors;

	function new();
		errors = 0;
	endfunction

	// square-and-multiply from the lsb, exact double-width products
	function automatic word_t predict_residue(word_t b, exp_t p, word_t m);
		logic [2*mexp_pkg::WIDTH-1:0] acc;
		logic [2*mexp_pkg::WIDTH-1:0] sq;
		logic [2*mexp_pkg::WIDTH-1:0] mw;
		exp_t                         e;
		if (m <= 1)
			return '0;
		mw  = (2*mexp_pkg::WIDTH)'(m);
		acc = (2*mexp_pkg::WIDTH)'(1);
		sq  = (2*mexp_pkg::WIDTH)'(b) % mw;
		e   = p;
		while (e != 0) begin
			if (e[0])
				acc = (acc * sq) % mw;
			sq = (sq * sq) % mw;
			e  = e >> 1;
		end
		return acc[mexp_pkg::WIDTH-1:0];
	endfunction

	function void note_input(word_t b, exp_t p, word_t m);
		pending.push_back(predict_residue(b, p, m));
	endfunction

	function void check_result(word_t got);
		word_t want;
		if (pending.size() == 0) begin
			$display("%0t: unexpected residue beat, expected none, actual %h", $time, got);
			errors++;
		end else begin
			want = pending.pop_front();
			if (got !== want) begin
				$display("%0t: residue mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		end
	endfunction
endclass

module modular_exponentiation_tb;

	logic  clk           = 1'b0;
	logic  arst_n        = 1'b0;
	logic  in_valid      = 1'b0;
	logic  in_stall;
	word_t base_value    = '0;
	exp_t  power         = '0;
	word_t modulus_value = '1;
	logic  out_valid;
	logic  out_stall     = 1'b0;
	word_t residue;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	residue_board board;

	modular_exponentiation uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.base_value    (base_value),
		.power         (power),
		.modulus_value (modulus_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.residue       (residue)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(residue);
	end

	task automatic send_beat(input word_t b, input exp_t p, input word_t m);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		base_value    <= b;
		power         <= p;
		modulus_value <= m;
		do
			@(posedge clk);
		while (in_stall);
		board.note_input(b, p, m);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		word_t b;
		exp_t  p;
		word_t m;
		for (int i = 0; i < count; i++) begin
			b = $urandom;
			p = $urandom >> $urandom_range(0, 31);
			if ($urandom_range(0, 7) == 0)
				m = $urandom_range(1, 16);
			else
				m = $urandom;
			if (m == 0)
				m = 1;
			if ($urandom_range(0, 15) == 0)
				p = '0;
			send_beat(b, p, m);
		end
	endtask

	initial begin
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_beat(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
		send_beat(32'h0000_0007, 32'h0000_0000, 32'h0000_000D);
		send_beat(32'h0000_0000, 32'h0000_0000, 32'h0000_0002);
		send_beat(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		send_beat(32'h0000_0000, 32'h0000_0005, 32'h0000_0061);
		send_beat(32'h0000_0003, 32'h0000_0005, 32'h0000_0002);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
		send_beat(32'h0000_0002, 32'h0000_001F, 32'hFFFF_FFFF);
		send_beat(32'h0000_0003, 32'hFFFF_FFFF, 32'hFFFF_FFFB);
		send_beat(32'h0000_0002, 32'h0000_000A, 32'h0000_03E8);
		send_beat(32'h075B_CD15, 32'h0000_0001, 32'h3ADE_68B1);
		send_beat(32'h3ADE_68B1, 32'h0000_0001, 32'h075B_CD15);
		send_beat(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
		send_beat(32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFFF);
		send_beat(32'h0000_3039, 32'h0001_0001, 32'hFFFF_FFF1);
		send_beat(32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF);
		send_beat(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001);
		send_beat(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0003);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_random(62);
		wait_drained();

		send_idle_pct  = 59;
		recv_stall_pct = 0;
		send_random(62);
		wait_drained();

		send_idle_pct  = 0;
		recv_stall_pct = 59;
		send_random(62);
		wait_drained();

		send_idle_pct  = 35;
		recv_stall_pct = 35;
		send_random(62);
		wait_drained();

		// tail for any stray beat
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: modular_exponentiation.f
rtl/mexp_pkg.sv
rtl/mexp_dp.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
tb/modular_exponentiation_tb.sv
